// ===== design/dsched_pkg.sv =====
// Shared constants, policy codes and controller/datapath interface types for the disk scheduler.
package dsched_pkg;

    localparam int TRK_W      = 16;
    localparam int TAG_W      = 16;
    localparam int PEND_W     = 5;
    localparam int POL_W      = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
    localparam logic [POL_W-1:0] POL_SSTF  = 2'd1;
    localparam logic [POL_W-1:0] POL_LOOK  = 2'd2;
    localparam logic [POL_W-1:0] POL_CLOOK = 2'd3;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_PICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_read;
        logic pick;
        logic fetch;
        logic shift;
        logic dec;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action;
        logic empty;
        logic scan_more;
        logic cmp_busy;
        logic fetch_tail;
        logic shift_last;
    } t_status;

endpackage

// ===== design/dsched_ctrl.sv =====
// Controller state machine of the disk scheduler: sequences add, scan, pick and compaction.
module dsched_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  dsched_pkg::t_status  i_status,
    output dsched_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.action == dsched_pkg::ACT_ADD || i_status.empty) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_read = i_status.scan_more;
                if (!i_status.scan_more && !i_status.cmp_busy) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_status.fetch_tail) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_RESP;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_last) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ===== design/dsched_dp.sv =====
// Datapath of the disk scheduler: slot memory, fill count, candidate search and result register.
module dsched_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dsched_pkg::POL_W-1:0]        i_cfg_wdata,
    input  logic                                i_in_action,
    input  logic [dsched_pkg::IN_DATA_W-1:0]    i_in_data,
    input  dsched_pkg::t_cmd                    i_cmd,
    output dsched_pkg::t_status                 o_status,
    output logic                                o_out_done,
    output logic [dsched_pkg::OUT_DATA_W-1:0]   o_out_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + 1;
    localparam int TRK_W = dsched_pkg::TRK_W;
    localparam int TAG_W = dsched_pkg::TAG_W;

    logic [TRK_W-1:0] r_mem_track [QUEUE_DEPTH];
    logic [TAG_W-1:0] r_mem_tag   [QUEUE_DEPTH];
    logic [TRK_W-1:0] r_rd_track;
    logic [TAG_W-1:0] r_rd_tag;

    logic [dsched_pkg::POL_W-1:0] r_policy;
    logic                         r_sweep_up;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_cnt;
    logic [IDX_W-1:0]             r_ptr;

    logic             r_action;
    logic [TRK_W-1:0] r_track;
    logic [TAG_W-1:0] r_tag;
    logic [TRK_W-1:0] r_head;

    logic             r_cmp_en;
    logic [IDX_W-1:0] r_cmp_idx;

    logic             r_v_all, r_v_up, r_v_dn, r_v_min;
    logic [IDX_W-1:0] r_i_all, r_i_up, r_i_dn, r_i_min;
    logic [TRK_W-1:0] r_d_all, r_d_up, r_d_dn, r_t_min;

    logic             r_done;
    logic [TRK_W-1:0] r_out_track;
    logic [TAG_W-1:0] r_out_tag;
    logic             r_o_done;
    logic [dsched_pkg::OUT_DATA_W-1:0] r_o_data;

    logic             w_empty;
    logic             w_full;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [TRK_W-1:0] w_wtrack;
    logic [TAG_W-1:0] w_wtag;
    logic [TRK_W-1:0] w_dist;
    logic             w_ge;
    logic             w_le;
    logic [IDX_W-1:0] w_k;
    logic             w_flip;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));

    // Read address: scan counter by default, the chosen slot at a pick,
    // and the slot after the hole while compacting.
    always_comb begin
        w_raddr = r_cnt[IDX_W-1:0];
        if (i_cmd.pick) begin
            w_raddr = w_k;
        end else if (i_cmd.fetch) begin
            w_raddr = r_ptr + IDX_W'(1);
        end else if (i_cmd.shift) begin
            w_raddr = r_ptr + IDX_W'(2);
        end
    end

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_ptr;
        w_wtrack = r_rd_track;
        w_wtag   = r_rd_tag;
        if (i_cmd.exec && r_action == dsched_pkg::ACT_ADD && !w_full) begin
            w_we     = 1'b1;
            w_waddr  = r_count[IDX_W-1:0];
            w_wtrack = r_track;
            w_wtag   = r_tag;
        end else if (i_cmd.shift) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_track[w_waddr] <= w_wtrack;
            r_mem_tag[w_waddr]   <= w_wtag;
        end
        r_rd_track <= r_mem_track[w_raddr];
        r_rd_tag   <= r_mem_tag[w_raddr];
    end

    assign w_ge   = (r_rd_track >= r_head);
    assign w_le   = (r_rd_track <= r_head);
    assign w_dist = w_ge ? (r_rd_track - r_head) : (r_head - r_rd_track);

    // Choice of slot; LOOK turns around when nothing lies in the sweep direction.
    always_comb begin
        w_k    = '0;
        w_flip = 1'b0;
        case (r_policy)
            dsched_pkg::POL_FIFO: begin
                w_k = '0;
            end
            dsched_pkg::POL_SSTF: begin
                w_k = r_i_all;
            end
            dsched_pkg::POL_LOOK: begin
                if (r_sweep_up) begin
                    w_k    = r_v_up ? r_i_up : r_i_dn;
                    w_flip = !r_v_up;
                end else begin
                    w_k    = r_v_dn ? r_i_dn : r_i_up;
                    w_flip = !r_v_dn;
                end
            end
            default: begin
                w_k = r_v_up ? r_i_up : r_i_min;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= dsched_pkg::POL_FIFO;
            r_sweep_up <= 1'b1;
            r_count    <= '0;
            r_cmp_en   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (i_cmd.pick && w_flip) begin
                r_sweep_up <= !r_sweep_up;
            end
            if (i_cmd.exec && r_action == dsched_pkg::ACT_ADD && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            r_cmp_en <= i_cmd.scan_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_in_action;
            r_track  <= i_in_data[TRK_W-1:0];
            r_tag    <= i_in_data[TRK_W+TAG_W-1:TRK_W];
            r_head   <= i_in_data[2*TRK_W+TAG_W-1:TRK_W+TAG_W];
        end
        if (i_cmd.scan_read) begin
            r_cnt     <= r_cnt + CNT_W'(1);
            r_cmp_idx <= r_cnt[IDX_W-1:0];
        end
        if (i_cmd.exec) begin
            r_done      <= (r_action == dsched_pkg::ACT_PICK) ? !w_empty : !w_full;
            r_out_track <= '0;
            r_out_tag   <= '0;
            r_cnt       <= '0;
            r_v_all     <= 1'b0;
            r_v_up      <= 1'b0;
            r_v_dn      <= 1'b0;
            r_v_min     <= 1'b0;
        end
        // Strict compares keep the oldest slot on ties.
        if (r_cmp_en) begin
            if (!r_v_all || w_dist < r_d_all) begin
                r_v_all <= 1'b1;
                r_i_all <= r_cmp_idx;
                r_d_all <= w_dist;
            end
            if (w_ge && (!r_v_up || w_dist < r_d_up)) begin
                r_v_up <= 1'b1;
                r_i_up <= r_cmp_idx;
                r_d_up <= w_dist;
            end
            if (w_le && (!r_v_dn || w_dist < r_d_dn)) begin
                r_v_dn <= 1'b1;
                r_i_dn <= r_cmp_idx;
                r_d_dn <= w_dist;
            end
            if (!r_v_min || r_rd_track < r_t_min) begin
                r_v_min <= 1'b1;
                r_i_min <= r_cmp_idx;
                r_t_min <= r_rd_track;
            end
        end
        if (i_cmd.pick) begin
            r_ptr <= w_k;
        end
        if (i_cmd.fetch) begin
            r_out_track <= r_rd_track;
            r_out_tag   <= r_rd_tag;
        end
        if (i_cmd.shift) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (i_cmd.load_out) begin
            r_o_done <= r_done;
            r_o_data <= {(dsched_pkg::OUT_DATA_W - dsched_pkg::PEND_W - TRK_W - TAG_W)'(0),
                         dsched_pkg::PEND_W'(r_count), r_out_track, r_out_tag};
        end
    end

    assign o_status.action     = r_action;
    assign o_status.empty      = w_empty;
    assign o_status.scan_more  = (r_cnt < r_count);
    assign o_status.cmp_busy   = r_cmp_en;
    assign o_status.fetch_tail = ((EXT_W'(r_ptr) + EXT_W'(1)) >= EXT_W'(r_count));
    assign o_status.shift_last = ((EXT_W'(r_ptr) + EXT_W'(2)) >= EXT_W'(r_count));

    assign o_out_done = r_o_done;
    assign o_out_data = r_o_data;

endmodule

// ===== design/disk_request_scheduler_top.sv =====
// Top level of the disk request scheduler: stream ports, controller and datapath.
//
//  Channel  | Direction | Transfer when               | Contents
//  ---------+-----------+-----------------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid & tready      | tuser action; tdata track, tag, head
//  m_axis   | out       | m_axis_tvalid & tready      | tuser done; tdata tag, track, pending
//  cfg      | in        | i_cfg_we                    | i_cfg_wdata policy
//
// One item is processed at a time. An add goes from capture through the exec and result states.
// A pick runs a search pass with one slot memory read per cycle, then picks and fetches
// the slot and moves one slot per cycle while the younger requests close the gap. Reset
// is synchronous and active low; it empties the store and sets the sweep toward higher
// tracks. The result waits in an output register, so a stall on m_axis only holds the
// block once the next result is ready to leave.
module disk_request_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dsched_pkg::POL_W-1:0]        i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0 up: track[15:0], tag[31:16], head[47:32].
    input  logic [dsched_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser fields: action[0].
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0 up: out_tag[15:0], out_track[31:16], pending[36:32].
    output logic [dsched_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser fields: done_res[0].
    output logic                                m_axis_tuser
);

    dsched_pkg::t_cmd    w_cmd;
    dsched_pkg::t_status w_status;

    // The controller owns the handshakes; the datapath owns every stored data value.
    dsched_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dsched_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_action (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_done  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== design/dsched_chk.sv =====
// Port-level checker for the disk request scheduler and its bind to the top level.
module dsched_chk #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dsched_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                                m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("refused item carries a tag or track");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && QUEUE_DEPTH < 32 |-> int'(m_axis_tdata[36:32]) <= QUEUE_DEPTH)
        else $error("pending count above store depth");

endmodule

bind disk_request_scheduler_top dsched_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dsched_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
